// ===== hdl/packet_framer_sum_checksum_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the packet framer
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef PACKET_FRAMER_SUM_CHECKSUM_ASSERT_SVH
`define PACKET_FRAMER_SUM_CHECKSUM_ASSERT_SVH

`ifndef ASSERT_OFF
// Checks that a condition holds on every clock edge outside reset.
`define PFSC_ASSERT(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
// Checks that a consequent holds in the same cycle as its antecedent.
`define PFSC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define PFSC_ASSERT(label, clk, rst, cond)
`define PFSC_ASSERT_IMPL(label, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/pfsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Packet framer package
// Shared constants, the front-to-back descriptor and the hex digit function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfsc_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] SHIFT_OUT       = 8'h0E;
  localparam logic [7:0] HDR_DIGIT       = 8'h30;
  localparam logic [7:0] CARRIAGE_RETURN = 8'h0D;
  localparam logic [7:0] HDR_SUM         = 8'h4C;

  // One accepted item that causes at least one output byte.
  typedef struct packed {
    logic       hdr;
    logic       has;
    logic [7:0] data;
    logic       last;
    logic [7:0] sum;
  } desc_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h57 + {4'd0, nib};
    end
    return c;
  endfunction

endpackage

// ===== hdl/pfsc_front.sv =====
// ----------------------------------------------------------------------------
// Packet framer front end
// Accepts items, tracks packet state and the running sum, and queues work.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfsc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,
  input  logic          s_tuser,
  input  logic          s_tlast,
  output logic          push,
  output pfsc_pkg::desc_t push_desc,
  input  logic          push_ready
);
  import pfsc_pkg::*;

  logic       in_packet;
  logic [7:0] running_sum;
  logic [7:0] sum_base;
  logic [7:0] sum_after;
  logic       accept;

  assign s_tready = push_ready;
  assign accept   = s_tvalid && s_tready;

  assign sum_base  = in_packet ? running_sum : HDR_SUM;
  assign sum_after = sum_base + (s_tuser ? s_tdata : 8'd0);

  assign push_desc.hdr  = !in_packet;
  assign push_desc.has  = s_tuser;
  assign push_desc.data = s_tdata;
  assign push_desc.last = s_tlast;
  assign push_desc.sum  = sum_after;

  // An item inside a packet with neither byte nor last flag has no output.
  assign push = accept && (!in_packet || s_tuser || s_tlast);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet   <= 1'b0;
      running_sum <= 8'd0;
    end else if (accept) begin
      if (s_tlast) begin
        in_packet   <= 1'b0;
        running_sum <= 8'd0;
      end else begin
        in_packet   <= 1'b1;
        running_sum <= sum_after;
      end
    end
  end

endmodule

// ===== hdl/pfsc_queue.sv =====
// ----------------------------------------------------------------------------
// Packet framer work queue
// Small first-in first-out buffer of descriptors between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfsc_queue #(
  parameter int unsigned DEPTH = pfsc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pfsc_pkg::desc_t push_desc,
  output logic            push_ready,
  input  logic            pop,
  output logic            q_valid,
  output pfsc_pkg::desc_t q_desc
);
  import pfsc_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  desc_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != FULL_CNT);
  assign q_valid    = (count != '0);
  assign q_desc     = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/pfsc_back.sv =====
// ----------------------------------------------------------------------------
// Packet framer back end
// Expands each descriptor into header, payload and trailer bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfsc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  pfsc_pkg::desc_t q_desc,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,
  output logic            m_tlast,
  output logic            m_tuser
);
  import pfsc_pkg::*;

  localparam logic [2:0] SLOT_HDR0 = 3'd0;
  localparam logic [2:0] SLOT_HDR1 = 3'd1;
  localparam logic [2:0] SLOT_HDR2 = 3'd2;
  localparam logic [2:0] SLOT_DATA = 3'd3;
  localparam logic [2:0] SLOT_HEXH = 3'd4;
  localparam logic [2:0] SLOT_HEXL = 3'd5;
  localparam logic [2:0] SLOT_CR   = 3'd6;

  logic [2:0] step;
  logic [6:0] mask;
  logic [6:0] avail;
  logic [6:0] rest;
  logic [2:0] slot;
  logic       done;
  logic       adv;
  logic [7:0] byte_next;

  assign mask  = {q_desc.last, q_desc.last, q_desc.last, q_desc.has,
                  q_desc.hdr, q_desc.hdr, q_desc.hdr};
  assign avail = mask & (7'h7F << step);

  // Lowest enabled slot at or after the current step.
  always_comb begin
    slot = SLOT_CR;
    for (int i = 6; i >= 0; i--) begin
      if (avail[i]) begin
        slot = 3'(i);
      end
    end
  end

  assign rest = avail & ~(7'b1 << slot);
  assign done = (rest == '0);
  assign adv  = q_valid && (!m_tvalid || m_tready);
  assign pop  = adv && done;

  always_comb begin
    case (slot)
      SLOT_HDR0: byte_next = SHIFT_OUT;
      SLOT_HDR1: byte_next = SHIFT_OUT;
      SLOT_HDR2: byte_next = HDR_DIGIT;
      SLOT_DATA: byte_next = q_desc.data;
      SLOT_HEXH: byte_next = hex_char(q_desc.sum[7:4]);
      SLOT_HEXL: byte_next = hex_char(q_desc.sum[3:0]);
      SLOT_CR:   byte_next = CARRIAGE_RETURN;
      default:   byte_next = CARRIAGE_RETURN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (adv) begin
        m_tvalid <= 1'b1;
        step     <= done ? 3'd0 : slot + 3'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= byte_next;
      m_tlast <= done;
      m_tuser <= (slot == SLOT_CR);
    end
  end

endmodule

// ===== hdl/packet_framer_sum_checksum.sv =====
// ----------------------------------------------------------------------------
// Packet framer with byte-sum checksum
// Wraps payload bytes in a header and a hex checksum trailer.
// ----------------------------------------------------------------------------
// A payload item in the middle of a packet gives one output byte and the block
// takes one such item per clock while m_tready holds and the queue has room. An
// item that opens a packet adds three header bytes and an item with the last
// flag adds two hex checksum digits and a carriage return, so one item gives up
// to seven output bytes, while an item inside a packet with neither a byte nor
// the last flag gives none. The back end has a single output byte register and
// the front end keeps taking items into a short descriptor queue until it fills.
`timescale 1ns / 1ps

module packet_framer_sum_checksum #(
  parameter int unsigned QUEUE_DEPTH = pfsc_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tuser,   // [0] has_byte
  input  logic       s_tlast,   // last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tuser,   // [0] frame_end
  output logic       m_tlast    // run_last
);
  import pfsc_pkg::*;

`include "packet_framer_sum_checksum_assert.svh"

  logic  push;
  logic  push_ready;
  desc_t push_desc;
  logic  pop;
  logic  q_valid;
  desc_t q_desc;

  pfsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .push       (push),
    .push_desc  (push_desc),
    .push_ready (push_ready)
  );

  pfsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .push_ready (push_ready),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_desc     (q_desc)
  );

  pfsc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_desc   (q_desc),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // Every queued descriptor must produce at least one byte.
  `PFSC_ASSERT_IMPL(a_desc_nonempty, clk, rst, q_valid, q_desc.hdr || q_desc.has || q_desc.last)
  `PFSC_ASSERT_IMPL(a_fend_is_cr, clk, rst, m_tvalid && m_tuser, m_tdata == CARRIAGE_RETURN)
  `PFSC_ASSERT_IMPL(a_fend_ends_run, clk, rst, m_tvalid && m_tuser, m_tlast)

endmodule
